FILE: rtl/nearest_neighbor_downscaler_core_macros.svh
// Assertion macros for the nearest-neighbor downscaler RTL.
// Uses clk_i and rst_ni of the including module; empty when SYNTH is defined.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_CORE_MACROS_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_CORE_MACROS_SVH
`ifndef SYNTH
`define NND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define NND_ASSERT_IMPL(lbl, ante, cons, msg) \
  `NND_ASSERT(lbl, (ante) |-> (cons), msg)
`define NND_ASSERT_NEXT(lbl, ante, cons, msg) \
  `NND_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define NND_ASSERT(lbl, prop, msg)
`define NND_ASSERT_IMPL(lbl, ante, cons, msg)
`define NND_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/nnd_pkg.sv
// Package for the nearest-neighbor downscaler: field widths and register codes.
// No dependencies.
`default_nettype none
package nnd_pkg;

  localparam int CFG_W   = 11;
  localparam int PIX_W   = 16;
  localparam int IDX_W   = 20;
  localparam int CIDX_W  = 2;
  localparam int SUM_W   = 2 * CFG_W;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DST_WIDTH  = 2'd0,
    CFG_DST_HEIGHT = 2'd1,
    CFG_SRC_WIDTH  = 2'd2,
    CFG_SRC_HEIGHT = 2'd3
  } cfg_reg_e;

endpackage
`default_nettype wire

FILE: rtl/nearest_neighbor_downscaler_core.sv
// Nearest-neighbor downscaler: a kept pixel's result is registered in the cycle after it is accepted.
// Throughput one pixel per cycle while the output is not stalled; the counter update and the output register
// both complete in the cycle the request is accepted.
// Reset: sizes return to 1, all counters to 0, output register empty.
// Depends on nnd_pkg and nearest_neighbor_downscaler_core_macros.svh.
`default_nettype none
`include "nearest_neighbor_downscaler_core_macros.svh"
module nearest_neighbor_downscaler_core #(
  parameter int MAX_DIM    = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [nnd_pkg::CIDX_W-1:0]  cfg_index_i,
  input  wire logic [nnd_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [nnd_pkg::PIX_W-1:0]   pixel_in_i,
  input  wire logic                        frame_start_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [nnd_pkg::PIX_W-1:0]        pixel_out_o,
  output logic [nnd_pkg::IDX_W-1:0]        dst_index_o,
  output logic                             frame_done_o
);

  localparam int CW = nnd_pkg::CFG_W;
  localparam int SW = nnd_pkg::SUM_W;
  localparam logic [nnd_pkg::PIX_W-1:0] PIX_MASK =
    (PIXEL_BITS >= nnd_pkg::PIX_W) ? {nnd_pkg::PIX_W{1'b1}} :
    nnd_pkg::PIX_W'((1 << PIXEL_BITS) - 1);

  logic [CW-1:0] dst_width_q, dst_height_q, src_width_q, src_height_q;

  logic [CW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [CW-1:0] dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [SW-1:0] col_sum_q, col_sum_d, col_tgt_q, col_tgt_d;
  logic [SW-1:0] row_sum_q, row_sum_d, row_tgt_q, row_tgt_d;

  logic                      out_valid_q;
  logic [nnd_pkg::PIX_W-1:0] pixel_q;
  logic [nnd_pkg::IDX_W-1:0] index_q;
  logic                      done_q;

  logic [CW-1:0] sc, sr, dc, dr;
  logic [SW-1:0] cs, ct, rs, rt;
  logic [CW:0]   sc_inc;
  logic          halted, cfg_ok, row_hit, col_hit, hit, in_acc;
  logic [SW-1:0] idx_full;
  logic          done_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_width_q  <= CW'(1);
      dst_height_q <= CW'(1);
      src_width_q  <= CW'(1);
      src_height_q <= CW'(1);
    end else if (cfg_valid_i) begin
      case (nnd_pkg::cfg_reg_e'(cfg_index_i))
        nnd_pkg::CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i;
        nnd_pkg::CFG_DST_HEIGHT: dst_height_q <= cfg_data_i;
        nnd_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i;
        nnd_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sc = frame_start_i ? '0 : src_col_q;
    sr = frame_start_i ? '0 : src_row_q;
    dc = frame_start_i ? '0 : dst_col_q;
    dr = frame_start_i ? '0 : dst_row_q;
    cs = frame_start_i ? '0 : col_sum_q;
    ct = frame_start_i ? '0 : col_tgt_q;
    rs = frame_start_i ? '0 : row_sum_q;
    rt = frame_start_i ? '0 : row_tgt_q;

    halted = (sr >= src_height_q);
    cfg_ok = (dst_width_q != '0) && (32'(dst_width_q) <= MAX_DIM) &&
             (dst_height_q != '0) && (32'(dst_height_q) <= MAX_DIM) &&
             (src_width_q != '0) && (32'(src_width_q) <= MAX_DIM) &&
             (src_height_q != '0) && (32'(src_height_q) <= MAX_DIM) &&
             (dst_width_q <= src_width_q) && (dst_height_q <= src_height_q);

    row_hit = cfg_ok && (dr < dst_height_q) &&
              ({1'b0, rt} < ({1'b0, rs} + (SW+1)'(dst_height_q)));
    col_hit = cfg_ok && (dc < dst_width_q) &&
              ({1'b0, ct} < ({1'b0, cs} + (SW+1)'(dst_width_q)));
    hit     = !halted && row_hit && col_hit;

    idx_full = SW'(dr) * SW'(dst_width_q) + SW'(dc);
    done_d   = ((CW+1)'(dr) + 1'b1 == (CW+1)'(dst_height_q)) &&
               ((CW+1)'(dc) + 1'b1 == (CW+1)'(dst_width_q));

    src_col_d = sc;
    src_row_d = sr;
    dst_col_d = dc;
    dst_row_d = dr;
    col_sum_d = cs;
    col_tgt_d = ct;
    row_sum_d = rs;
    row_tgt_d = rt;
    sc_inc    = (CW+1)'(sc) + 1'b1;

    if (!halted) begin
      if (hit) begin
        dst_col_d = dc + 1'b1;
        col_tgt_d = ct + SW'(src_width_q);
      end
      src_col_d = sc_inc[CW-1:0];
      col_sum_d = cs + SW'(dst_width_q);
      if (sc_inc >= (CW+1)'(src_width_q)) begin
        src_col_d = '0;
        col_sum_d = '0;
        dst_col_d = '0;
        col_tgt_d = '0;
        if (row_hit) begin
          dst_row_d = dr + 1'b1;
          row_tgt_d = rt + SW'(src_height_q);
        end
        src_row_d = sr + 1'b1;
        row_sum_d = rs + SW'(dst_height_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      col_sum_q <= '0;
      col_tgt_q <= '0;
      row_sum_q <= '0;
      row_tgt_q <= '0;
    end else if (in_acc) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      col_sum_q <= col_sum_d;
      col_tgt_q <= col_tgt_d;
      row_sum_q <= row_sum_d;
      row_tgt_q <= row_tgt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_acc && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && hit) begin
      pixel_q <= pixel_in_i & PIX_MASK;
      index_q <= idx_full[nnd_pkg::IDX_W-1:0];
      done_q  <= done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_q;
  assign dst_index_o  = index_q;
  assign frame_done_o = done_q;

  // stalled result blocks new requests
  `NND_ASSERT_IMPL(a_stall_blocks_in, out_valid_q && !out_ready_i, !in_ready_o,
                   "input accepted while result stalled")
  `NND_ASSERT_NEXT(a_start_clears_col, in_acc && frame_start_i, src_col_q <= CW'(1),
                   "frame start did not restart column count")
  `NND_ASSERT_IMPL(a_result_from_request, $rose(out_valid_q),
                   $past(in_valid_i && in_ready_o),
                   "result appeared without accepted pixel")

endmodule
`default_nettype wire
